// File: src/cell_count_histogram_top_macros.svh
// Assertion macros used by the checker file (cch_checker.sv).
`ifndef CELL_COUNT_HISTOGRAM_TOP_MACROS_SVH
`define CELL_COUNT_HISTOGRAM_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define CCH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CCH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checked during reset as well.
`define CCH_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cch_pkg.sv
`default_nettype none
package cch_pkg;

   localparam int OPCODE_W    = 2;
   localparam int CELL_W      = 16;
   localparam int MAX_COUNT_W = 10;
   localparam int PIX_OUT_W   = 24;
   localparam int USED_W      = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * PIX_OUT_W - USED_W;

   localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMPTY_VALUE = 1'b1;

   localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RESET   = 10'd1023;
   localparam logic [CELL_W-1:0]      EMPTY_VALUE_RESET = 16'hFFFF;
   localparam logic [USED_W-1:0]      USED_MAX          = 11'h7FF;

   typedef struct packed {
      logic load_item;
      logic commit;
      logic sweep;
   } cch_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic item_is_clear;
   } cch_status_type;

endpackage
`default_nettype wire

// File: src/cch_ctrl.sv
`default_nettype none
module cch_ctrl
   import cch_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire cch_status_type status,
   output cch_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      commit;

   assign accept = req_tvalid && ready_ff;
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               ready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            // a clear drops every bin through a sweep before the next word
            if (commit) begin
               state_in = status.item_is_clear ? ST_CLEAR : ST_IDLE;
               ready_in = !status.item_is_clear;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ready_in = 1'b0;
         end
      endcase

      if (commit)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready    = ready_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign cmd.load_item = accept;
   assign cmd.commit    = commit;
   assign cmd.sweep     = (state_ff == ST_CLEAR);

endmodule
`default_nettype wire

// File: src/cch_datapath.sv
`default_nettype none
module cch_datapath
   import cch_pkg::*;
#(
   parameter int NUM_BINS         = 1024,
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [CELL_W-1:0]      req_cell_value,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire cch_cmd_type            cmd,
   output cch_status_type              status,
   output logic [PIX_OUT_W-1:0]        rsp_bin_pixels,
   output logic [PIX_OUT_W-1:0]        rsp_total_pixels,
   output logic [USED_W-1:0]          rsp_nonzero_bins,
   output logic                        rsp_out_of_range
);

   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int WORD_W = PIXEL_COUNT_BITS + 1;
   localparam logic [CELL_W:0]              BIN_LIMIT = (CELL_W + 1)'(NUM_BINS);
   localparam logic [IDX_W-1:0]             LAST_IDX  = IDX_W'(NUM_BINS - 1);
   localparam logic [PIXEL_COUNT_BITS-1:0]  COUNT_MAX = '1;

   // each word: valid bit on top, bin count below
   logic [WORD_W-1:0] mem [NUM_BINS];

   logic [MAX_COUNT_W-1:0]      max_count_ff;
   logic [CELL_W-1:0]           empty_value_ff;
   logic [OPCODE_W-1:0]         op_ff;
   logic [CELL_W-1:0]           val_ff;
   logic [WORD_W-1:0]           rd_data_ff;
   logic [IDX_W-1:0]            sweep_ff;
   logic [PIXEL_COUNT_BITS-1:0] total_ff, total_in;
   logic [USED_W-1:0]           used_ff, used_in;
   logic [PIX_OUT_W-1:0]        bin_out_ff;
   logic [PIX_OUT_W-1:0]        total_out_ff;
   logic [USED_W-1:0]           used_out_ff;
   logic                        oor_ff;

   logic                        rd_en;
   logic                        in_range;
   logic                        is_add, is_read, is_clear, not_empty;
   logic                        counted;
   logic                        oor;
   logic [PIXEL_COUNT_BITS-1:0] cur_count, new_count, bin_value;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [WORD_W-1:0]           wr_data;

   assign rd_en = cmd.load_item && ({1'b0, req_cell_value} < BIN_LIMIT);

   assign is_add    = (op_ff == OP_ADD);
   assign is_read   = (op_ff == OP_READ);
   assign is_clear  = (op_ff == OP_CLEAR);
   assign not_empty = (val_ff != empty_value_ff);
   assign in_range  = (val_ff <= CELL_W'(max_count_ff)) && ({1'b0, val_ff} < BIN_LIMIT);

   always_comb begin
      cur_count = rd_data_ff[PIXEL_COUNT_BITS] ? rd_data_ff[PIXEL_COUNT_BITS-1:0] : '0;
      new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
      counted   = is_add && not_empty && in_range;
      oor       = (is_add && not_empty && !in_range) || (is_read && !in_range);

      if (counted)
         bin_value = new_count;
      else if (is_read && in_range)
         bin_value = cur_count;
      else
         bin_value = '0;

      total_in = total_ff;
      used_in  = used_ff;
      if (is_clear) begin
         total_in = '0;
         used_in  = '0;
      end else if (counted) begin
         if (total_ff != COUNT_MAX)
            total_in = total_ff + 1'b1;
         if (cur_count == '0 && used_ff != USED_MAX)
            used_in = used_ff + 1'b1;
      end

      // sweep owns the write port while clearing
      wr_en   = cmd.sweep || (cmd.commit && counted);
      wr_addr = cmd.sweep ? sweep_ff : val_ff[IDX_W-1:0];
      wr_data = cmd.sweep ? '0 : {1'b1, new_count};
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[req_cell_value[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff   <= MAX_COUNT_RESET;
         empty_value_ff <= EMPTY_VALUE_RESET;
         sweep_ff       <= '0;
         total_ff       <= '0;
         used_ff        <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MAX_COUNT:   max_count_ff   <= csr_data[MAX_COUNT_W-1:0];
               CSR_EMPTY_VALUE: empty_value_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.sweep)
            sweep_ff <= (sweep_ff == LAST_IDX) ? '0 : sweep_ff + 1'b1;
         if (cmd.commit) begin
            total_ff <= total_in;
            used_ff  <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_opcode;
         val_ff <= req_cell_value;
      end
      if (cmd.commit) begin
         bin_out_ff   <= PIX_OUT_W'(bin_value);
         total_out_ff <= PIX_OUT_W'(total_in);
         used_out_ff  <= used_in;
         oor_ff       <= oor;
      end
   end

   assign status.sweep_last    = cmd.sweep && (sweep_ff == LAST_IDX);
   assign status.item_is_clear = is_clear;

   assign rsp_bin_pixels   = bin_out_ff;
   assign rsp_total_pixels = total_out_ff;
   assign rsp_nonzero_bins = used_out_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
`default_nettype wire

// File: src/cell_count_histogram_top.sv
// Histogram engine for per-pixel iteration counts. Each request word carries
// an opcode in req_tuser (add, read, clear) and a cell value in req_tdata;
// every request returns exactly one response word with the addressed bin
// count, the saturating pixel total, the non-zero bin count and an
// out-of-range flag. Bins live in a single-port-write, registered-read RAM of
// NUM_BINS words, so an add or read completes before the next accept
// (read the bin, then write it back and load the response register);
// a pending response does not block the next request until its write-back.
// A clear responds right away, then sweeps the RAM one bin per cycle with
// req_tready low. The same sweep runs after reset. The CSR port (index 0
// max_count, index 1 empty_value) is always ready; write it only while the
// block is idle.
`default_nettype none
module cell_count_histogram_top
   import cch_pkg::*;
#(
   parameter int NUM_BINS         = 1024,
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [15:0] cell_value
   input  wire logic [OPCODE_W-1:0]    req_tuser,  // [1:0] opcode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [23:0] bin_pixels, [47:24] total_pixels, [58:48] nonzero_bins, rest zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tuser,  // [0] out_of_range
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cch_cmd_type          cmd;
   cch_status_type       status;
   logic [PIX_OUT_W-1:0] bin_pixels;
   logic [PIX_OUT_W-1:0] total_pixels;
   logic [USED_W-1:0]    nonzero_bins;

   cch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cch_datapath #(
      .NUM_BINS         (NUM_BINS),
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_tuser),
      .req_cell_value   (req_tdata),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_bin_pixels   (bin_pixels),
      .rsp_total_pixels (total_pixels),
      .rsp_nonzero_bins (nonzero_bins),
      .rsp_out_of_range (rsp_tuser)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, nonzero_bins, total_pixels, bin_pixels};

endmodule
`default_nettype wire

// File: src/cch_checker.sv
`default_nettype none
`include "cell_count_histogram_top_macros.svh"
module cch_checker
   import cch_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic [OPCODE_W-1:0]    req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_data
);

   // a stalled response word holds
   `CCH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // a dropped value never reports a bin count
   `CCH_ASSERT_SAME(a_oor_zero_bin, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[23:0] == 24'd0, "out-of-range response carries a bin count")

   // a counted bin implies at least one non-zero bin
   `CCH_ASSERT_SAME(a_bin_used, clock, reset, rsp_tvalid && (rsp_tdata[23:0] != 24'd0),
      rsp_tdata[58:48] != 11'd0, "non-zero bin with zero used-bin count")

   // reset starts the clearing sweep with nothing pending
   `CCH_ASSERT_ALWAYS_NEXT(a_reset_quiet, clock, reset,
      !rsp_tvalid && !req_tready, "block not quiet after reset")

   logic unused_ok;
   assign unused_ok = ^{req_tvalid, req_tdata, req_tuser, csr_valid, csr_ready,
                        csr_index, csr_data, rsp_tdata[RSP_TDATA_W-1:59], rsp_tdata[47:24]};

endmodule

bind cell_count_histogram_top cch_checker u_cch_checker (.*);
`default_nettype wire
